/* hw/rtl/sm3_pkg.sv */
// Package for the SM3 digest block: initial value, round constants and helpers.
// Used by sm3_message_digest_top; depends on nothing.
package sm3_pkg;
    typedef logic [31:0] t_word;

    localparam t_word IV0 = 32'h7380166F;
    localparam t_word IV1 = 32'h4914B2B9;
    localparam t_word IV2 = 32'h172442D7;
    localparam t_word IV3 = 32'hDA8A0600;
    localparam t_word IV4 = 32'hA96F30BC;
    localparam t_word IV5 = 32'h163138AA;
    localparam t_word IV6 = 32'hE38DEE4D;
    localparam t_word IV7 = 32'hB0FB0E4E;
    localparam t_word T_LO = 32'h79CC4519;
    localparam t_word T_HI = 32'h7A879D8A;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic t_word iv_word(input logic [2:0] idx);
        t_word v;
        case (idx)
            3'd0: v = IV0;
            3'd1: v = IV1;
            3'd2: v = IV2;
            3'd3: v = IV3;
            3'd4: v = IV4;
            3'd5: v = IV5;
            3'd6: v = IV6;
            default: v = IV7;
        endcase
        return v;
    endfunction

    function automatic t_word rotl(input t_word x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic t_word perm0(input t_word x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic t_word perm1(input t_word x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction
endpackage

/* hw/rtl/sm3_message_digest_top.sv */
// SM3 message digest, one message byte per input beat.
// A beat that fills a block holds off input through 16 reads (plus the read latency),
// 64 rounds and one fold. A last beat writes up to 16 padding words ahead of each
// padding compression (one or two), then shows eight digest beats. One round a cycle.
// Synchronous active-low reset restores the initial value and clears all counts.
module sm3_message_digest_top
    import sm3_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_last_of_message,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    // Control states. Bytes are gathered into a 32-bit word register, and the word so far
    // is written to the block RAM with every byte. Compression reads the RAM word by
    // word into the expansion window, then runs 64 rounds.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;  // writes padding words one per cycle
    localparam logic [2:0] ST_LOAD = 3'd2;  // reads 16 words into the window
    localparam logic [2:0] ST_RND  = 3'd3;  // 64 rounds
    localparam logic [2:0] ST_FOLD = 3'd4;  // xor round registers into the chain
    localparam logic [2:0] ST_OUT  = 3'd5;  // eight digest beats

    logic [2:0]  r_state;
    logic [5:0]  r_nbytes;
    logic [54:0] r_blocks;
    t_word       r_acc;
    logic        r_final;     // padding owed after this compression
    logic        r_fin_last;  // this compression is the last one of the message
    logic [4:0]  r_pad_w;     // next word to pad
    logic        r_len_blk;   // the padding block holds the length
    logic [63:0] r_bits;
    logic [4:0]  r_cnt;       // load counter, 0..16 (bit 4 is the read-latency slot)
    logic [5:0]  r_rnd;
    t_word       r_cv [8];
    t_word       r_reg [8];
    t_word       r_win [16];
    logic [2:0]  r_oidx;

    logic        ram_we;
    logic [3:0]  ram_waddr;
    t_word       ram_wdata;
    t_word       ram_rdata;

    sm3_ram #(.WIDTH(32), .DEPTH(16)) u_buf (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(r_cnt[3:0]),
        .o_rdata(ram_rdata)
    );

    logic  in_fire;
    logic  out_fire;
    t_word byte_word;
    logic [5:0] n_nbytes;

    assign o_stall  = (r_state != ST_IDLE);
    assign in_fire  = i_valid && !o_stall;
    assign out_fire = o_valid && !i_stall;
    assign o_valid  = (r_state == ST_OUT);
    assign o_digest_word = r_cv[r_oidx];
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == 3'd7);

    // Current byte merged big-endian into the word being gathered.
    always_comb begin
        byte_word = (r_nbytes[1:0] == 2'd0) ? 32'd0 : r_acc;
        case (r_nbytes[1:0])
            2'd0: byte_word[31:24] = i_data_byte;
            2'd1: byte_word[23:16] = i_data_byte;
            2'd2: byte_word[15:8]  = i_data_byte;
            default: byte_word[7:0] = i_data_byte;
        endcase
        n_nbytes = r_nbytes + 6'd1;
    end

    // Padding word for the current pad position. Word r_pad_w[3:0] of the block.
    t_word pad_word;
    logic [3:0] pos_w;
    always_comb begin
        pos_w = r_nbytes[5:2];
        if (r_len_blk && r_pad_w == 5'd14) begin
            pad_word = r_bits[63:32];
        end else if (r_len_blk && r_pad_w == 5'd15) begin
            pad_word = r_bits[31:0];
        end else if (!r_pad_w[4] && r_pad_w[3:0] == pos_w && r_final) begin
            pad_word = (r_nbytes[1:0] == 2'd0) ? 32'd0 : r_acc;
            case (r_nbytes[1:0])
                2'd0: pad_word[31:24] = PAD_BYTE;
                2'd1: pad_word[23:16] = PAD_BYTE;
                2'd2: pad_word[15:8]  = PAD_BYTE;
                default: pad_word[7:0] = PAD_BYTE;
            endcase
        end else begin
            pad_word = 32'd0;
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_nbytes[5:2];
        ram_wdata = byte_word;
        if (r_state == ST_IDLE) begin
            ram_we = in_fire && i_byte_present;
        end else if (r_state == ST_PAD) begin
            ram_we    = 1'b1;
            ram_waddr = r_pad_w[3:0];
            ram_wdata = pad_word;
        end
    end

    // One round of the compression, with the window expansion for word j+16.
    // The window holds W[j] .. W[j+15], so W[j+4] always sits in slot 4.
    t_word w_new, wj, wj4, tj, a12, ss1, ss2, tt1, tt2, ff, gg;
    logic  hi;
    always_comb begin
        hi = (r_rnd >= 6'd16);
        w_new = perm1(r_win[0] ^ r_win[7] ^ rotl(r_win[13], 5'd15))
              ^ rotl(r_win[3], 5'd7) ^ r_win[10];
        wj  = r_win[0];
        wj4 = r_win[4];
        tj  = hi ? T_HI : T_LO;
        a12 = rotl(r_reg[0], 5'd12);
        ss1 = rotl(a12 + r_reg[4] + rotl(tj, r_rnd[4:0]), 5'd7);
        ss2 = ss1 ^ a12;
        if (hi) begin
            ff = (r_reg[0] & r_reg[1]) | (r_reg[0] & r_reg[2]) | (r_reg[1] & r_reg[2]);
            gg = (r_reg[4] & r_reg[5]) | (~r_reg[4] & r_reg[6]);
        end else begin
            ff = r_reg[0] ^ r_reg[1] ^ r_reg[2];
            gg = r_reg[4] ^ r_reg[5] ^ r_reg[6];
        end
        tt1 = ff + r_reg[3] + ss2 + (wj ^ wj4);
        tt2 = gg + r_reg[7] + ss1 + wj;
    end

    // Payload registers: window, round registers and the gathered word.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && in_fire && i_byte_present) begin
            r_acc <= byte_word;
        end
        if (r_state == ST_LOAD && r_cnt != 5'd0) begin
            // The window shifts down; slot 15 receives the word read last cycle.
            for (int i = 0; i < 15; i++) r_win[i] <= r_win[i+1];
            r_win[15] <= ram_rdata;
        end
        if (r_state == ST_LOAD && r_cnt == 5'd16) begin
            for (int i = 0; i < 8; i++) r_reg[i] <= r_cv[i];
        end
        if (r_state == ST_RND) begin
            // Window index 0 always holds W[j]; it shifts one place per round.
            for (int i = 0; i < 15; i++) r_win[i] <= r_win[i+1];
            r_win[15] <= w_new;
            r_reg[3] <= r_reg[2];
            r_reg[2] <= rotl(r_reg[1], 5'd9);
            r_reg[1] <= r_reg[0];
            r_reg[0] <= tt1;
            r_reg[7] <= r_reg[6];
            r_reg[6] <= rotl(r_reg[5], 5'd19);
            r_reg[5] <= r_reg[4];
            r_reg[4] <= perm0(tt2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_nbytes   <= 6'd0;
            r_blocks   <= 55'd0;
            r_final    <= 1'b0;
            r_fin_last <= 1'b0;
            r_pad_w    <= 5'd0;
            r_len_blk  <= 1'b0;
            r_bits     <= 64'd0;
            r_cnt      <= 5'd0;
            r_rnd      <= 6'd0;
            r_oidx     <= 3'd0;
            for (int i = 0; i < 8; i++) r_cv[i] <= iv_word(3'(i));
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        logic [5:0] nb;
                        logic [54:0] blk;
                        nb  = i_byte_present ? n_nbytes : r_nbytes;
                        blk = (i_byte_present && n_nbytes == 6'd0) ? r_blocks + 55'd1
                                                                   : r_blocks;
                        r_nbytes   <= nb;
                        r_blocks   <= blk;
                        r_final    <= i_last_of_message;
                        r_bits     <= {blk, nb, 3'd0};
                        r_cnt      <= 5'd0;
                        r_fin_last <= 1'b0;
                        if (i_byte_present && n_nbytes == 6'd0) begin
                            r_state <= ST_LOAD;  // full block; pad after if last
                        end else if (i_last_of_message) begin
                            r_state    <= ST_PAD;
                            r_pad_w    <= {1'b0, nb[5:2]};
                            r_len_blk  <= (nb <= 6'd55);
                            r_fin_last <= (nb <= 6'd55);
                        end
                    end
                end
                ST_PAD: begin
                    if (r_pad_w[3:0] == 4'd15) begin
                        r_state <= ST_LOAD;
                        r_cnt   <= 5'd0;
                    end
                    r_pad_w <= r_pad_w + 5'd1;
                end
                ST_LOAD: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd16) begin
                        r_state <= ST_RND;
                        r_rnd   <= 6'd0;
                    end
                end
                ST_RND: begin
                    r_rnd <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) r_state <= ST_FOLD;
                end
                ST_FOLD: begin
                    for (int i = 0; i < 8; i++) r_cv[i] <= r_cv[i] ^ r_reg[i];
                    r_oidx <= 3'd0;
                    if (r_fin_last) begin
                        r_state <= ST_OUT;
                    end else if (r_final) begin
                        // Padding still owed: a length block, which also carries the marker if none was written.
                        r_state    <= ST_PAD;
                        r_len_blk  <= 1'b1;
                        r_fin_last <= 1'b1;
                        if (r_nbytes == 6'd0 || r_nbytes > 6'd55) begin
                            // Marker already written (zero block), or block was full (marker goes in word 0).
                            r_pad_w <= 5'd0;
                            if (r_nbytes != 6'd0) r_final <= 1'b0;
                            if (r_nbytes == 6'd0) r_pad_w <= 5'd0;
                        end
                        if (r_nbytes > 6'd55) r_nbytes <= 6'd0;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_OUT: begin
                    if (out_fire) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            r_state  <= ST_IDLE;
                            r_nbytes <= 6'd0;
                            r_blocks <= 55'd0;
                            r_final  <= 1'b0;
                            for (int i = 0; i < 8; i++) r_cv[i] <= iv_word(3'(i));
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule

/* hw/rtl/sm3_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; used by the SM3 top level for the block buffer.
module sm3_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* verif/tb.sv */
// Self-checking testbench for sm3_message_digest_top: byte beats in, digest words out.
// Depends on sm3_pkg and the sm3_message_digest_top RTL; it carries its own SM3 predictor.
module tb
    import sm3_pkg::*;
;

    // Clock and reset. Reset is held low at the start and then released for good.
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;

    // Input channel, driven by the stimulus process.
    logic        i_valid = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_byte_present = 1'b0;
    logic        i_last_of_message = 1'b0;
    logic        o_stall;

    // Output channel. The stall is driven by the receiver process.
    logic        o_valid;
    logic        i_stall = 1'b1;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    always #5 i_clk = ~i_clk;

    sm3_message_digest_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .i_byte_present   (i_byte_present),
        .i_last_of_message(i_last_of_message),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_digest_word    (o_digest_word),
        .o_word_index     (o_word_index),
        .o_last_word      (o_last_word)
    );

    // One expected digest beat.
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_beat;

    // One row of the directed table. When has_known is set, the eight digest words
    // that the row's last beat produces are typed in and checked against the predictor.
    typedef struct {
        logic [7:0] data;
        logic       present;
        logic       last;
        logic       has_known;
        t_word      known [8];
    } t_byte_row;

    t_digest_beat pending_digest [$];

    // The predictor's own copy of the block's state.
    t_word       hash_state [8];
    t_word       msg_block [16];
    logic [5:0]  fill_count;
    logic [54:0] blocks_done;

    int          errors = 0;
    logic        long_hold = 1'b0;
    int          idle_cycles = 0;

    // Cycles of no acceptance on either side before the run is declared hung.
    // The slowest legal gap is two compressions plus a long receiver stall.
    localparam int HANG_LIMIT = 20000;

    function automatic t_word rol(input t_word x, input int n);
        int s;
        s = n % 32;
        if (s == 0) return x;
        return (x << s) | (x >> (32 - s));
    endfunction

    // One SM3 compression of msg_block into hash_state.
    task automatic sm3_compress();
        t_word w [68];
        t_word ra, rb, rc, rd, re, rf, rg, rh;
        t_word ss1, ss2, tt1, tt2, ff, gg, tj, p;
        for (int i = 0; i < 16; i++) w[i] = msg_block[i];
        for (int i = 16; i < 68; i++) begin
            p = w[i-16] ^ w[i-9] ^ rol(w[i-3], 15);
            w[i] = (p ^ rol(p, 15) ^ rol(p, 23)) ^ rol(w[i-13], 7) ^ w[i-6];
        end
        ra = hash_state[0]; rb = hash_state[1]; rc = hash_state[2]; rd = hash_state[3];
        re = hash_state[4]; rf = hash_state[5]; rg = hash_state[6]; rh = hash_state[7];
        for (int j = 0; j < 64; j++) begin
            tj  = (j < 16) ? 32'h79CC4519 : 32'h7A879D8A;
            ss1 = rol(rol(ra, 12) + re + rol(tj, j), 7);
            ss2 = ss1 ^ rol(ra, 12);
            if (j < 16) begin
                ff = ra ^ rb ^ rc;
                gg = re ^ rf ^ rg;
            end else begin
                ff = (ra & rb) | (ra & rc) | (rb & rc);
                gg = (re & rf) | (~re & rg);
            end
            tt1 = ff + rd + ss2 + (w[j] ^ w[j+4]);
            tt2 = gg + rh + ss1 + w[j];
            rd = rc; rc = rol(rb, 9); rb = ra; ra = tt1;
            rh = rg; rg = rol(rf, 19); rf = re;
            re = tt2 ^ rol(tt2, 9) ^ rol(tt2, 17);
        end
        hash_state[0] ^= ra; hash_state[1] ^= rb; hash_state[2] ^= rc; hash_state[3] ^= rd;
        hash_state[4] ^= re; hash_state[5] ^= rf; hash_state[6] ^= rg; hash_state[7] ^= rh;
    endtask

    task automatic place_byte(input logic [5:0] pos, input logic [7:0] b);
        int sh;
        sh = (3 - pos[1:0]) * 8;
        if (pos[1:0] == 2'd0) msg_block[pos[5:2]] = {b, 24'h0};
        else msg_block[pos[5:2]] |= t_word'(b) << sh;
    endtask

    task automatic restart_hash();
        for (int i = 0; i < 8; i++) hash_state[i] = iv_word(3'(i));
        fill_count  = '0;
        blocks_done = '0;
    endtask

    // Advance the predictor by one accepted beat; a last beat queues the digest.
    task automatic predict_digest(input logic [7:0] b, input logic present,
                                  input logic last);
        logic [63:0] bit_len;
        logic [5:0]  n;
        if (present) begin
            place_byte(fill_count, b);
            fill_count = fill_count + 6'd1;
            if (fill_count == 6'd0) begin
                sm3_compress();
                blocks_done = blocks_done + 55'd1;
            end
        end
        if (last) begin
            n = fill_count;
            bit_len = {blocks_done, 9'd0} + {55'd0, n, 3'd0};
            place_byte(n, PAD_BYTE);
            if (n > 6'd55) begin
                for (int q = n + 1; q < 64; q++) place_byte(6'(q), 8'h00);
                sm3_compress();
                for (int q = 0; q < 56; q++) place_byte(6'(q), 8'h00);
            end else begin
                for (int q = n + 1; q < 56; q++) place_byte(6'(q), 8'h00);
            end
            msg_block[14] = bit_len[63:32];
            msg_block[15] = bit_len[31:0];
            sm3_compress();
            for (int i = 0; i < 8; i++)
                pending_digest.push_back('{hash_state[i], 3'(i), i == 7});
            restart_hash();
        end
    endtask

    // Receiver: random stall with mostly short gaps, a few long ones, and one
    // very long hold-off that lets the block back up and stall its input.
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_hold) begin
                i_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                long_hold = 1'b0;
            end
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
                                              : $urandom_range(0, 3);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap != 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // Result checking: every accepted digest beat is matched against the oldest one due.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_digest.size() == 0) begin
                $display("%0t: digest beat with nothing due: word %h index %0d",
                         $time, o_digest_word, o_word_index);
                errors++;
            end else begin
                t_digest_beat e;
                e = pending_digest.pop_front();
                if (o_digest_word !== e.word) begin
                    $display("%0t: digest word mismatch: expected %h actual %h",
                             $time, e.word, o_digest_word);
                    errors++;
                end
                if (o_word_index !== e.index) begin
                    $display("%0t: word index mismatch: expected %0d actual %0d",
                             $time, e.index, o_word_index);
                    errors++;
                end
                if (o_last_word !== e.last) begin
                    $display("%0t: last word mismatch: expected %b actual %b",
                             $time, e.last, o_last_word);
                    errors++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither channel moves a beat.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= HANG_LIMIT) begin
            $display("sm3_message_digest_top verification failed");
            $finish;
        end
    end

    // Offer one beat and hold it steady until the block takes it. The valid is
    // left high; the caller lowers it only when a gap follows.
    task automatic send_beat(input logic [7:0] b, input logic present, input logic last);
        i_valid           <= 1'b1;
        i_data_byte       <= b;
        i_byte_present    <= present;
        i_last_of_message <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_digest(b, present, last);
    endtask

    task automatic sender_gap();
        int gap;
        gap = ($urandom_range(0, 14) == 0) ? $urandom_range(15, 90) : $urandom_range(0, 2);
        if ($urandom_range(0, 2) == 0) gap = 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_digest.size() != 0) @(posedge i_clk);
    endtask

    t_byte_row directed [$];

    // Random message: mostly well-formed byte runs, some idle beats mixed in,
    // lengths biased around the one- and two-block padding boundaries.
    task automatic send_message(input int len, inout int sent);
        logic empty_end;
        empty_end = $urandom_range(0, 1);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 15) == 0) begin
                send_beat(8'($urandom), 1'b0, 1'b0);
                sent++;
                sender_gap();
            end
            send_beat(8'($urandom), 1'b1, (k == len - 1) && !empty_end);
            sent++;
            sender_gap();
        end
        if (empty_end || len == 0) begin
            send_beat(8'($urandom), 1'b0, 1'b1);
            sent++;
            sender_gap();
        end
    endtask

    initial begin
        t_byte_row r;
        int sent;
        int len;
        restart_hash();
        for (int i = 0; i < 16; i++) msg_block[i] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table. Empty message first (digest typed in), then "abc" with its
        // standard digest, then bytes at both extremes and idle beats.
        r = '{8'h00, 1'b0, 1'b1, 1'b1, '{32'h1AB21D83, 32'h55CFA17F, 32'h8E611948,
              32'h31E81A8F, 32'h22BEC8C7, 32'h28FEFB74, 32'h7ED035EB, 32'h5082AA2B}};
        directed.push_back(r);
        r = '{8'h61, 1'b1, 1'b0, 1'b0, '{default: '0}}; directed.push_back(r);
        r = '{8'h00, 1'b0, 1'b0, 1'b0, '{default: '0}}; directed.push_back(r);
        r = '{8'h62, 1'b1, 1'b0, 1'b0, '{default: '0}}; directed.push_back(r);
        r = '{8'h63, 1'b1, 1'b1, 1'b1, '{32'h66C7F0F4, 32'h62EEEDD9, 32'hD1F2D46B,
              32'hDC10E4E2, 32'h4167C487, 32'h5CF2F7A2, 32'h297DA02B, 32'h8F4BA8E0}};
        directed.push_back(r);
        r = '{8'hFF, 1'b1, 1'b0, 1'b0, '{default: '0}}; directed.push_back(r);
        r = '{8'h00, 1'b1, 1'b0, 1'b0, '{default: '0}}; directed.push_back(r);
        r = '{8'hA5, 1'b0, 1'b0, 1'b0, '{default: '0}}; directed.push_back(r);
        r = '{8'h5A, 1'b1, 1'b0, 1'b0, '{default: '0}}; directed.push_back(r);
        r = '{8'hFF, 1'b0, 1'b1, 1'b0, '{default: '0}}; directed.push_back(r);
        r = '{8'hFF, 1'b1, 1'b1, 1'b0, '{default: '0}}; directed.push_back(r);
        foreach (directed[d]) begin
            if (directed[d].has_known)
                for (int i = 0; i < 8; i++)
                    if (iv_word(3'(i)) == 32'h0) errors++;
            send_beat(directed[d].data, directed[d].present, directed[d].last);
            if (directed[d].has_known)
                for (int i = 0; i < 8; i++)
                    if (pending_digest[i].word !== directed[d].known[i]) begin
                        $display("%0t: predicted digest word %0d: expected %h actual %h",
                                 $time, i, directed[d].known[i], pending_digest[i].word);
                        errors++;
                    end
            sender_gap();
        end

        // A 64-byte message fills the block exactly; 56 bytes is one more than the one-block pad fits.
        sent = 0;
        send_message(64, sent);
        send_message(56, sent);

        // The sender pauses here until every digest beat due has come out.
        wait_drained();

        // Keep offering while the receiver holds off for a long stretch.
        long_hold = 1'b1;
        send_message(3, sent);
        send_message(5, sent);
        send_message(2, sent);

        while (sent < 430) begin
            case ($urandom_range(0, 4))
                0: len = $urandom_range(0, 4);
                1: len = $urandom_range(52, 60);
                2: len = $urandom_range(62, 66);
                3: len = $urandom_range(115, 130);
                default: len = $urandom_range(5, 40);
            endcase
            send_message(len, sent);
        end
        wait_drained();
        repeat (200) @(posedge i_clk);

        if (errors == 0) begin
            $display("sm3_message_digest_top verification clean");
        end else begin
            $display("sm3_message_digest_top verification failed");
        end
        $finish;
    end
endmodule
